### design/bam_pkg.sv
`default_nettype none

package bam_pkg;

    // Request codes carried in the op field.
    localparam logic [2:0] OP_CONTIG     = 3'd0;
    localparam logic [2:0] OP_INDEX_OPEN = 3'd1;
    localparam logic [2:0] OP_INDEX_DATA = 3'd2;
    localparam logic [2:0] OP_FORCE_MARK = 3'd3;
    localparam logic [2:0] OP_CLAIM      = 3'd4;
    localparam logic [2:0] OP_FIRST_FREE = 3'd5;

    // Completion codes carried in the status field.
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_RANGE   = 3'd1;
    localparam logic [2:0] ST_USED    = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_NOINDEX = 3'd4;

    // One request as held in the input register.
    typedef struct packed {
        logic       clear_all;
        logic       list_last;
        logic [7:0] run_length;
        logic [6:0] block;
        logic [2:0] op;
    } req_t;

    // One response as produced by the engine.
    typedef struct packed {
        logic [6:0] result_block;
        logic [2:0] status;
    } rsp_t;

endpackage

`default_nettype wire

### design/bam_engine.sv
`default_nettype none

module bam_engine #(
    parameter int BLOCKS = 64
) (
    input  wire           clk,
    input  wire           rst_n,
    input  wire           fire,
    input  bam_pkg::req_t req,
    output bam_pkg::rsp_t rsp
);

    localparam int IDXW = $clog2(BLOCKS);

    logic [BLOCKS-1:0] used_reg;
    logic [BLOCKS-1:0] used_next;
    logic [BLOCKS-1:0] pending_reg;
    logic [BLOCKS-1:0] pending_next;
    logic              index_open_reg;
    logic              index_open_next;
    logic [IDXW-1:0]   open_blk_reg;
    logic [IDXW-1:0]   open_blk_next;

    logic              in_range;
    logic [IDXW-1:0]   idx;
    logic [8:0]        run_end;
    logic              run_over;
    logic [BLOCKS-1:0] run_mask;
    logic [BLOCKS-1:0] busy;
    logic              any_busy;
    logic [IDXW-1:0]   first_busy;
    logic              any_free;
    logic [IDXW-1:0]   first_free;
    logic [BLOCKS-1:0] blk_bit;
    logic [BLOCKS-1:0] open_bit;

    // Request decode and range checks.
    assign in_range = {1'b0, req.block} < 8'(BLOCKS);
    assign idx      = req.block[IDXW-1:0];
    assign run_end  = {2'b00, req.block} + {1'b0, req.run_length};
    assign run_over = run_end > 9'(BLOCKS);
    assign blk_bit  = BLOCKS'(1) << idx;
    assign open_bit = BLOCKS'(1) << open_blk_reg;

    // Mask of the requested run and the busy blocks inside it.
    always_comb
    begin
        for (int i = 0; i < BLOCKS; i++)
        begin
            run_mask[i] = (9'(i) >= {2'b00, req.block}) && (9'(i) < run_end);
        end
    end

    assign busy = used_reg & run_mask;

    // Lowest busy block in the run and lowest free block in the map.
    always_comb
    begin
        any_busy   = 1'b0;
        first_busy = '0;
        any_free   = 1'b0;
        first_free = '0;
        for (int i = BLOCKS - 1; i >= 0; i--)
        begin
            if (busy[i])
            begin
                any_busy   = 1'b1;
                first_busy = IDXW'(i);
            end
            if (!used_reg[i])
            begin
                any_free   = 1'b1;
                first_free = IDXW'(i);
            end
        end
    end

    // Next state and response for the request in the input register.
    always_comb
    begin
        used_next       = used_reg;
        pending_next    = pending_reg;
        index_open_next = index_open_reg;
        open_blk_next   = open_blk_reg;
        rsp.status       = bam_pkg::ST_OK;
        rsp.result_block = req.block;

        unique case (req.op)
            bam_pkg::OP_CONTIG:
            begin
                if (!in_range || run_over)
                begin
                    rsp.status = bam_pkg::ST_RANGE;
                end
                else if (any_busy)
                begin
                    rsp.status       = bam_pkg::ST_USED;
                    rsp.result_block = 7'(first_busy);
                end
                else
                begin
                    used_next = used_reg | run_mask;
                end
            end
            bam_pkg::OP_INDEX_OPEN:
            begin
                // An open list is abandoned first, which frees its index block.
                if (index_open_reg)
                begin
                    used_next       = used_next & ~open_bit;
                    pending_next    = '0;
                    index_open_next = 1'b0;
                    open_blk_next   = '0;
                end
                if (!in_range)
                begin
                    rsp.status = bam_pkg::ST_RANGE;
                end
                else if (used_next[idx])
                begin
                    rsp.status = bam_pkg::ST_USED;
                end
                else
                begin
                    used_next       = used_next | blk_bit;
                    index_open_next = 1'b1;
                    open_blk_next   = idx;
                    pending_next    = '0;
                end
            end
            bam_pkg::OP_INDEX_DATA:
            begin
                if (!index_open_reg)
                begin
                    rsp.status = bam_pkg::ST_NOINDEX;
                end
                else if (!in_range || used_reg[idx])
                begin
                    rsp.status      = in_range ? bam_pkg::ST_USED : bam_pkg::ST_RANGE;
                    used_next       = used_reg & ~open_bit;
                    pending_next    = '0;
                    index_open_next = 1'b0;
                    open_blk_next   = '0;
                end
                else if (req.list_last)
                begin
                    used_next       = used_reg | pending_reg | blk_bit;
                    pending_next    = '0;
                    index_open_next = 1'b0;
                    open_blk_next   = '0;
                end
                else
                begin
                    pending_next = pending_reg | blk_bit;
                end
            end
            bam_pkg::OP_FORCE_MARK:
            begin
                if (!in_range)
                begin
                    rsp.status = bam_pkg::ST_RANGE;
                end
                else
                begin
                    used_next = used_reg | blk_bit;
                end
            end
            bam_pkg::OP_CLAIM:
            begin
                if (!in_range)
                begin
                    rsp.status = bam_pkg::ST_RANGE;
                end
                else if (used_reg[idx])
                begin
                    rsp.status = bam_pkg::ST_USED;
                end
                else
                begin
                    used_next = used_reg | blk_bit;
                end
            end
            bam_pkg::OP_FIRST_FREE:
            begin
                rsp.result_block = '0;
                if (req.clear_all)
                begin
                    used_next       = '0;
                    pending_next    = '0;
                    index_open_next = 1'b0;
                    open_blk_next   = '0;
                end
                else if (!any_free)
                begin
                    rsp.status = bam_pkg::ST_FULL;
                end
                else
                begin
                    rsp.result_block = 7'(first_free);
                    used_next        = used_reg | (BLOCKS'(1) << first_free);
                end
            end
            default:
            begin
                rsp.status = bam_pkg::ST_RANGE;
            end
        endcase
    end

    // Bitmap and list state, updated once per processed request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg       <= '0;
            pending_reg    <= '0;
            index_open_reg <= 1'b0;
            open_blk_reg   <= '0;
        end
        else if (fire)
        begin
            used_reg       <= used_next;
            pending_reg    <= pending_next;
            index_open_reg <= index_open_next;
            open_blk_reg   <= open_blk_next;
        end
    end

    // A closed list never keeps collected blocks.
    assert property (@(posedge clk) disable iff (!rst_n)
        !index_open_reg |-> (pending_reg == '0))
        else $error("pending mask not empty while no list is open");

    // The index block of an open list stays marked as used.
    assert property (@(posedge clk) disable iff (!rst_n)
        index_open_reg |-> used_reg[open_blk_reg])
        else $error("open index block is not marked used");

    // A block handed out as lowest free is marked used afterwards.
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && req.op == bam_pkg::OP_FIRST_FREE && !req.clear_all
            && rsp.status == bam_pkg::ST_OK)
        |=> used_reg[$past(rsp.result_block[IDXW-1:0])])
        else $error("found free block was not claimed");

endmodule

`default_nettype wire

### design/block_allocation_bitmap_unit.sv
// Block allocation bitmap unit.
// A result passes through the input register, which loads at the input transfer,
// and then the result register, which loads once it frees up; the bitmap update
// and the range and priority search happen in between.
// Throughput: one request per cycle while the result side keeps up.
// Reset: all blocks free, pending mask empty, no indexed list open.
`default_nettype none

module block_allocation_bitmap_unit #(
    parameter int BLOCKS = 64
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [15:0] s_tdata,   // block[6:0], run_length[14:7], zero pad
    input  wire  [3:0]  s_tuser,   // op[2:0], clear_all[3]
    input  wire         s_tlast,   // list_last
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [15:0] m_tdata    // status[2:0], result_block[9:3], zero pad
);

    logic          in_valid_reg;
    bam_pkg::req_t req_reg;
    logic          out_valid_reg;
    bam_pkg::rsp_t rsp_reg;
    bam_pkg::rsp_t rsp;
    logic          advance;
    logic          fire;
    logic          s_xfer;

    // The result register frees up when empty or when its transfer completes.
    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign s_xfer   = s_tvalid && s_tready;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_xfer)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_xfer)
        begin
            req_reg.op         <= s_tuser[2:0];
            req_reg.clear_all  <= s_tuser[3];
            req_reg.block      <= s_tdata[6:0];
            req_reg.run_length <= s_tdata[14:7];
            req_reg.list_last  <= s_tlast;
        end
    end

    // Bitmap state and request evaluation.
    bam_engine #(
        .BLOCKS (BLOCKS)
    ) u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .req   (req_reg),
        .rsp   (rsp)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            rsp_reg <= rsp;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b000000, rsp_reg.result_block, rsp_reg.status};

endmodule

`default_nettype wire
